[hw/rtl/nns_pkg.sv]
// Shared constants for the one-dimensional nearest-neighbor search block.
// Used by the channel interfaces and the search unit.
`default_nettype none

package nns_pkg;

  localparam int unsigned IDX_W      = 10;  // width of a reference index field
  localparam int unsigned VAL_W      = 16;  // unsigned Q0.16 sample width
  localparam int unsigned CNT_CFG_W  = 11;  // ref_count register width
  localparam int unsigned CFG_ADDR_W = 3;   // byte address of the register port
  localparam int unsigned CFG_DATA_W = 32;

  // Operation codes carried by the input channel.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Register index, taken from the word address of the register port.
  localparam logic REG_REF_COUNT = 1'b0;

  // Distance reported when no reference was compared.
  localparam logic [VAL_W-1:0] DIST_MAX = '1;

endpackage : nns_pkg

`default_nettype wire

[hw/rtl/nns_if.sv]
// Valid/ready channel interfaces for query/load beats and result beats.
// Depends on nns_pkg for field widths.
`default_nettype none

interface nns_in_if;
  import nns_pkg::*;

  logic             valid;
  logic             ready;
  logic             operation;
  logic [IDX_W-1:0] ref_index;
  logic [VAL_W-1:0] sample_value;

  modport source (output valid, output operation, output ref_index,
                  output sample_value, input ready);
  modport sink   (input valid, input operation, input ref_index,
                  input sample_value, output ready);
endinterface : nns_in_if

interface nns_out_if;
  import nns_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] nearest_index;
  logic [VAL_W-1:0] distance;
  logic             empty_set;

  modport source (output valid, output nearest_index, output distance,
                  output empty_set, input ready);
  modport sink   (input valid, input nearest_index, input distance,
                  input empty_set, output ready);
endinterface : nns_out_if

`default_nettype wire

[hw/rtl/nns_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module nns_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : nns_ram

`default_nettype wire

[hw/rtl/nearest_neighbor_search_1d_unit.sv]
// Brute-force 1-D nearest-neighbor search over a RAM of reference values.
// Load beat: written to the reference RAM at its accept edge if its index is in range; loads go back to back.
// Search beat: one RAM read per cycle over min(ref_count, REF_DEPTH) entries, then the
// result is registered (an empty set reads no entries); the next beat is taken the cycle after the result is
// registered, later while the previous result still waits in the output register.
// Synchronous active-low reset clears ref_count and control state; RAM stays undefined.
`default_nettype none

module nearest_neighbor_search_1d_unit #(
  parameter int unsigned REF_DEPTH = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  nns_in_if.sink                              in_ch,
  nns_out_if.source                           out_ch,
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [nns_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [nns_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [nns_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                                cfg_pready
);

  import nns_pkg::*;

  // Address width of the reference RAM and width of a counter that can hold
  // the full depth.
  localparam int unsigned ADDR_W = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(REF_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // ---------------------------------------------------------------------------
  // Register port. Only ref_count exists; writes to other word addresses are
  // dropped and read back as zero. The port never inserts wait states.
  // ---------------------------------------------------------------------------
  logic [CNT_CFG_W-1:0] ref_count_r;
  logic                 cfg_wr;
  logic                 cfg_reg_idx;

  assign cfg_pready  = 1'b1;
  assign cfg_reg_idx = cfg_paddr[2];
  assign cfg_wr      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_prdata = '0;
    if (cfg_reg_idx == REG_REF_COUNT) begin
      cfg_prdata = CFG_DATA_W'(ref_count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_count_r <= '0;
    end else if (cfg_wr && (cfg_reg_idx == REG_REF_COUNT)) begin
      ref_count_r <= cfg_pwdata[CNT_CFG_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Search engine state.
  // ---------------------------------------------------------------------------
  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;          // next RAM entry to read
  logic [CNT_W-1:0]    limit_r, limit_nxt;      // entries this search covers
  logic [VAL_W-1:0]    query_r, query_nxt;
  logic                rv_r, rv_nxt;            // RAM read data valid next cycle
  logic [ADDR_W-1:0]   ridx_r, ridx_nxt;        // index of the entry being read
  logic                found_r, found_nxt;
  logic [ADDR_W-1:0]   best_idx_r, best_idx_nxt;
  logic [VAL_W-1:0]    best_dist_r, best_dist_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]    out_idx_r, out_idx_nxt;
  logic [VAL_W-1:0]    out_dist_r, out_dist_nxt;
  logic                out_empty_r, out_empty_nxt;

  logic                in_acc;
  logic                ram_we;
  logic                load_in_range;
  logic [VAL_W-1:0]    ram_rdata;
  logic [VAL_W-1:0]    diff;
  logic [31:0]         limit_full;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Loads beyond the store are dropped.
  assign load_in_range = (32'(in_ch.ref_index) < 32'(REF_DEPTH));
  assign ram_we        = in_acc && (in_ch.operation == OP_LOAD) && load_in_range;

  // A ref_count beyond the store saturates at the store depth.
  assign limit_full = (32'(ref_count_r) > 32'(REF_DEPTH)) ? 32'(REF_DEPTH)
                                                          : 32'(ref_count_r);

  nns_ram #(
    .WIDTH (VAL_W),
    .DEPTH (REF_DEPTH)
  ) u_ref_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(in_ch.ref_index)),
    .wdata (in_ch.sample_value),
    .raddr (cnt_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // Absolute difference between the returning reference and the query.
  assign diff = (ram_rdata >= query_r) ? (ram_rdata - query_r)
                                       : (query_r - ram_rdata);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    limit_nxt     = limit_r;
    query_nxt     = query_r;
    rv_nxt        = 1'b0;
    ridx_nxt      = cnt_r[ADDR_W-1:0];
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_dist_nxt = best_dist_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_dist_nxt  = out_dist_r;
    out_empty_nxt = out_empty_r;

    // The result register frees as soon as its beat is taken.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_ch.operation == OP_SEARCH)) begin
          query_nxt     = in_ch.sample_value;
          limit_nxt     = CNT_W'(limit_full);
          cnt_nxt       = '0;
          found_nxt     = 1'b0;
          best_idx_nxt  = '0;
          best_dist_nxt = DIST_MAX;
          state_nxt     = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // Issue one read per cycle until every covered entry has been read.
        if (cnt_r != limit_r) begin
          rv_nxt  = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        // Compare the entry read last cycle. The compare is strict, so the
        // lowest index wins among equal distances.
        if (rv_r && (!found_r || (diff < best_dist_r))) begin
          found_nxt     = 1'b1;
          best_dist_nxt = diff;
          best_idx_nxt  = ridx_r;
        end
        if ((cnt_r == limit_r) && !rv_r) begin
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        // Hold the result until the output register can take it. An empty
        // search leaves index zero and the maximum distance in place.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = IDX_W'(best_idx_r);
          out_dist_nxt  = best_dist_r;
          out_empty_nxt = !found_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cnt_r       <= cnt_nxt;
    limit_r     <= limit_nxt;
    query_r     <= query_nxt;
    ridx_r      <= ridx_nxt;
    found_r     <= found_nxt;
    best_idx_r  <= best_idx_nxt;
    best_dist_r <= best_dist_nxt;
    out_idx_r   <= out_idx_nxt;
    out_dist_r  <= out_dist_nxt;
    out_empty_r <= out_empty_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.nearest_index = out_idx_r;
  assign out_ch.distance      = out_dist_r;
  assign out_ch.empty_set     = out_empty_r;

endmodule : nearest_neighbor_search_1d_unit

`default_nettype wire
